### design/erap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erap_pkg;

  // field and datapath widths
  localparam int COORD_W = 32;
  localparam int DATA_W  = 36;
  localparam int TRIG_W  = 16;
  localparam int PROD_W  = DATA_W + TRIG_W;
  localparam int FRAC_W  = 14;
  localparam int CFG_W   = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ROLL  = 3'd5;

  // cos 1.0, sin 0.0
  localparam logic [CFG_W-1:0] TRIG_RESET = 32'h4000_0000;

  typedef logic signed [DATA_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
    logic                      last_in;
  } in_data_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      saturated;
    logic                      last_out;
  } out_data_t;

  // load enables for the two registered stages of one plane rotation
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } rot_ctl_t;

endpackage

`default_nettype wire

### design/erap_rot.sv
`timescale 1ns / 1ps
`default_nettype none

// plane rotation: a' = a*c - b*s, b' = a*s + b*c, each term floored by 2^14
module erap_rot (
  input  wire logic              clk,
  input  wire erap_pkg::rot_ctl_t ctl,
  input  wire erap_pkg::coord_t  a_i,
  input  wire erap_pkg::coord_t  b_i,
  input  wire erap_pkg::trig_t   c_i,
  input  wire erap_pkg::trig_t   s_i,
  output erap_pkg::coord_t       a_o,
  output erap_pkg::coord_t       b_o
);

  localparam int PW = erap_pkg::PROD_W;
  localparam int FW = erap_pkg::FRAC_W;
  localparam int DW = erap_pkg::DATA_W;

  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [PW-1:0] pac_nxt, pbs_nxt, pas_nxt, pbc_nxt;
  erap_pkg::coord_t     a_r, b_r, a_nxt, b_nxt;

  // product stage: four exact 36x16 products
  always_comb begin
    pac_nxt = PW'(a_i) * PW'(c_i);
    pbs_nxt = PW'(b_i) * PW'(s_i);
    pas_nxt = PW'(a_i) * PW'(s_i);
    pbc_nxt = PW'(b_i) * PW'(c_i);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      pac_r <= pac_nxt;
      pbs_r <= pbs_nxt;
      pas_r <= pas_nxt;
      pbc_r <= pbc_nxt;
    end
  end

  // sum stage: arithmetic shift by the fraction bits, then wrap to the datapath width
  always_comb begin
    a_nxt = pac_r[FW+DW-1:FW] - pbs_r[FW+DW-1:FW];
    b_nxt = pas_r[FW+DW-1:FW] + pbc_r[FW+DW-1:FW];
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign a_o = a_r;
  assign b_o = b_r;

endmodule

`default_nettype wire

### design/euler_rotate_about_pivot.sv
`timescale 1ns / 1ps
`default_nettype none

// Rotates one Q16.16 vertex per beat about the configured pivot: yaw (z), then
// pitch (y), then roll (x), with cosine/sine pairs written as Q1.14 values. The
// pipeline has eight registered stages (pivot subtract, a product and a sum stage
// per axis on four 36x16 multipliers, then pivot add with saturation); out_valid
// rises once an accepted vertex has passed through every stage, and one vertex
// is taken every cycle while the output side keeps up. Each stage stalls on its
// own, so empty stages still fill while a result waits. Configuration must be
// written only while the pipeline is empty, which the block itself does not
// enforce; writes take effect at once and have no read-back.
module euler_rotate_about_pivot (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire erap_pkg::in_data_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output erap_pkg::out_data_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [erap_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [erap_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int NS = 8;
  localparam int CW = erap_pkg::COORD_W;
  localparam int DW = erap_pkg::DATA_W;

  // configuration registers
  logic signed [CW-1:0]         pivot_x_r, pivot_y_r, pivot_z_r;
  logic [erap_pkg::CFG_W-1:0]   trig_yaw_r, trig_pitch_r, trig_roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r    <= '0;
      pivot_y_r    <= '0;
      pivot_z_r    <= '0;
      trig_yaw_r   <= erap_pkg::TRIG_RESET;
      trig_pitch_r <= erap_pkg::TRIG_RESET;
      trig_roll_r  <= erap_pkg::TRIG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        erap_pkg::CFG_PIVOT_X:    pivot_x_r    <= cfg_wdata;
        erap_pkg::CFG_PIVOT_Y:    pivot_y_r    <= cfg_wdata;
        erap_pkg::CFG_PIVOT_Z:    pivot_z_r    <= cfg_wdata;
        erap_pkg::CFG_TRIG_YAW:   trig_yaw_r   <= cfg_wdata;
        erap_pkg::CFG_TRIG_PITCH: trig_pitch_r <= cfg_wdata;
        erap_pkg::CFG_TRIG_ROLL:  trig_roll_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-stage valid bits and backpressure chain
  logic [NS-1:0] valid_r, valid_nxt;
  logic [NS:0]   ready;
  logic [NS-2:0] last_r;

  always_comb begin
    ready[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (ready[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // last-vertex mark rides along with each stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS - 1; k++) begin
      if (ready[k]) begin
        last_r[k] <= (k == 0) ? in_data.last_in : last_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign in_ready = ready[0];

  // stage 0: pivot-relative coordinates
  erap_pkg::coord_t x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      x0_r <= DW'(in_data.x_in) - DW'(pivot_x_r);
      y0_r <= DW'(in_data.y_in) - DW'(pivot_y_r);
      z0_r <= DW'(in_data.z_in) - DW'(pivot_z_r);
    end
  end

  // stages 1-2: yaw, rotates x and y; z waits alongside
  erap_pkg::rot_ctl_t yaw_ctl, pitch_ctl, roll_ctl;
  erap_pkg::coord_t   yaw_x, yaw_y, pitch_z, pitch_x, roll_y, roll_z;
  erap_pkg::coord_t   z1_r, z2_r, y3_r, y4_r, x5_r, x6_r;

  assign yaw_ctl   = '{mul_en: ready[1], add_en: ready[2]};
  assign pitch_ctl = '{mul_en: ready[3], add_en: ready[4]};
  assign roll_ctl  = '{mul_en: ready[5], add_en: ready[6]};

  erap_rot u_yaw (
    .clk (clk),
    .ctl (yaw_ctl),
    .a_i (x0_r),
    .b_i (y0_r),
    .c_i (trig_yaw_r[31:16]),
    .s_i (trig_yaw_r[15:0]),
    .a_o (yaw_x),
    .b_o (yaw_y)
  );

  // stages 3-4: pitch, rotates z and x; y waits alongside
  erap_rot u_pitch (
    .clk (clk),
    .ctl (pitch_ctl),
    .a_i (z2_r),
    .b_i (yaw_x),
    .c_i (trig_pitch_r[31:16]),
    .s_i (trig_pitch_r[15:0]),
    .a_o (pitch_z),
    .b_o (pitch_x)
  );

  // stages 5-6: roll, rotates y and z; x waits alongside
  erap_rot u_roll (
    .clk (clk),
    .ctl (roll_ctl),
    .a_i (y4_r),
    .b_i (pitch_z),
    .c_i (trig_roll_r[31:16]),
    .s_i (trig_roll_r[15:0]),
    .a_o (roll_y),
    .b_o (roll_z)
  );

  // delay lines for the coordinate that an axis leaves untouched
  always_ff @(posedge clk) begin
    if (ready[1]) z1_r <= z0_r;
    if (ready[2]) z2_r <= z1_r;
    if (ready[3]) y3_r <= yaw_y;
    if (ready[4]) y4_r <= y3_r;
    if (ready[5]) x5_r <= pitch_x;
    if (ready[6]) x6_r <= x5_r;
  end

  // stage 7: add the pivot back and clamp to 32 bits
  function automatic logic [CW:0] sat_add(erap_pkg::coord_t v, logic signed [CW-1:0] p);
    logic signed [DW:0] sum;
    logic [CW:0]        res;
    sum = (DW + 1)'(v) + (DW + 1)'(p);
    if (sum > (DW + 1)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
      res = {1'b1, 1'b0, {(CW-1){1'b1}}};
    end else if (sum < -((DW + 1)'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}})))) begin
      res = {1'b1, 1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, sum[CW-1:0]};
    end
    return res;
  endfunction

  logic [CW:0]         sx, sy, sz;
  erap_pkg::out_data_t out_r, out_nxt;

  always_comb begin
    sx = sat_add(x6_r, pivot_x_r);
    sy = sat_add(roll_y, pivot_y_r);
    sz = sat_add(roll_z, pivot_z_r);
    out_nxt.x_out     = sx[CW-1:0];
    out_nxt.y_out     = sy[CW-1:0];
    out_nxt.z_out     = sz[CW-1:0];
    out_nxt.saturated = sx[CW] | sy[CW] | sz[CW];
    out_nxt.last_out  = last_r[NS-2];
  end

  always_ff @(posedge clk) begin
    if (ready[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r[NS-1];
  assign out_data  = out_r;

  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted beat not captured in stage 0");

  // a stalled middle stage keeps its beat and its mark
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] && !ready[3] |=> valid_r[3] && $stable(last_r[3]))
    else $error("stalled beat lost in stage 3");

  // backpressure only ever comes from a full first stage
  a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> valid_r[0] && !ready[1])
    else $error("input stalled with room in the pipeline");

  // a clamp always leaves an extreme value on some coordinate
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.x_out == 32'sh7fff_ffff) || (out_data.x_out == 32'sh8000_0000) ||
      (out_data.y_out == 32'sh7fff_ffff) || (out_data.y_out == 32'sh8000_0000) ||
      (out_data.z_out == 32'sh7fff_ffff) || (out_data.z_out == 32'sh8000_0000))
    else $error("saturated flag without a clamped coordinate");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import erap_pkg::*;

  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_data_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_data_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // register copies as the block should hold them
  logic [CFG_W-1:0] cfg_shadow [6];

  in_data_t  vertex_q[$];    // vertices waiting to be sent
  out_data_t rotated_q[$];   // rotated vertices still owed by the block
  out_data_t want;
  int        idle_pct    = 0;
  int        send_gap    = 0;
  int        stall_left  = 0;
  int        error_count = 0;

  euler_rotate_about_pivot dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // keep the low 36 bits as a two's complement value
  function automatic longint wrap36(longint v);
    coord_t w;
    w = v[DATA_W-1:0];
    return w;
  endfunction

  // exact product with a Q1.14 factor, floored by the arithmetic shift
  function automatic longint q14(longint v, trig_t f);
    longint p;
    p = v * longint'(f);
    return p >>> FRAC_W;
  endfunction

  function automatic logic [31:0] clamp32(longint v, inout logic hit);
    if (v > SAT_HI) begin
      hit = 1'b1;
      return SAT_HI[31:0];
    end
    if (v < SAT_LO) begin
      hit = 1'b1;
      return SAT_LO[31:0];
    end
    return v[31:0];
  endfunction

  function automatic out_data_t rotate_vertex(in_data_t v);
    longint    px, py, pz, x, y, z, a, b;
    trig_t     cz, sz, cy, sy, cx, sx;
    logic      hit;
    out_data_t r;
    px = $signed(cfg_shadow[CFG_PIVOT_X]);
    py = $signed(cfg_shadow[CFG_PIVOT_Y]);
    pz = $signed(cfg_shadow[CFG_PIVOT_Z]);
    cz = cfg_shadow[CFG_TRIG_YAW][31:16];
    sz = cfg_shadow[CFG_TRIG_YAW][15:0];
    cy = cfg_shadow[CFG_TRIG_PITCH][31:16];
    sy = cfg_shadow[CFG_TRIG_PITCH][15:0];
    cx = cfg_shadow[CFG_TRIG_ROLL][31:16];
    sx = cfg_shadow[CFG_TRIG_ROLL][15:0];
    // move to pivot-relative coordinates
    x = wrap36(longint'($signed(v.x_in)) - px);
    y = wrap36(longint'($signed(v.y_in)) - py);
    z = wrap36(longint'($signed(v.z_in)) - pz);
    // yaw about z
    a = wrap36(q14(x, cz) - q14(y, sz));
    b = wrap36(q14(x, sz) + q14(y, cz));
    x = a;
    y = b;
    // pitch about y
    a = wrap36(q14(x, cy) + q14(z, sy));
    b = wrap36(q14(z, cy) - q14(x, sy));
    x = a;
    z = b;
    // roll about x
    a = wrap36(q14(y, cx) - q14(z, sx));
    b = wrap36(q14(y, sx) + q14(z, cx));
    y = a;
    z = b;
    // back to absolute coordinates, clamped to 32 bits
    hit = 1'b0;
    r.x_out     = clamp32(x + px, hit);
    r.y_out     = clamp32(y + py, hit);
    r.z_out     = clamp32(z + pz, hit);
    r.saturated = hit;
    r.last_out  = v.last_in;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] corner(int i);
    case (i % 8)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      5: return 32'hFFFF_0000;
      6: return 32'h5555_5555;
      default: return 32'hAAAA_AAAA;
    endcase
  endfunction

  function automatic logic [31:0] random_pivot();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  // mostly true angles, some arbitrary and some extreme non-unit pairs
  function automatic logic [31:0] random_trig();
    real ang;
    int  c, s;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000),
                 ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
      default: begin
        ang = $urandom_range(0, 3599) * 3.141592653589793 / 1800.0;
        c = $rtoi(16384.0 * $cos(ang));
        s = $rtoi(16384.0 * $sin(ang));
        return {c[15:0], s[15:0]};
      end
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
  endfunction

  function automatic in_data_t random_vertex();
    in_data_t v;
    v.last_in = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 3))
      0: begin
        v.x_in = $urandom;
        v.y_in = $urandom;
        v.z_in = $urandom;
      end
      1: begin
        v.x_in = near('0);
        v.y_in = near('0);
        v.z_in = near('0);
      end
      default: begin
        v.x_in = near(cfg_shadow[CFG_PIVOT_X]);
        v.y_in = near(cfg_shadow[CFG_PIVOT_Y]);
        v.z_in = near(cfg_shadow[CFG_PIVOT_Z]);
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_shadow[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_corners(input int count);
    in_data_t v;
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      v.x_in    = corner(i);
      v.y_in    = corner(i + 3);
      v.z_in    = corner(i + 5);
      v.last_in = i[0];
      vertex_q.push_back(v);
    end
  endtask

  // every result is owed back, so an empty store means an empty pipeline
  task automatic drain();
    do @(negedge clk);
    while (vertex_q.size() != 0 || in_valid || rotated_q.size() != 0);
  endtask

  initial begin
    cfg_shadow[CFG_PIVOT_X]    = '0;
    cfg_shadow[CFG_PIVOT_Y]    = '0;
    cfg_shadow[CFG_PIVOT_Z]    = '0;
    cfg_shadow[CFG_TRIG_YAW]   = TRIG_RESET;
    cfg_shadow[CFG_TRIG_PITCH] = TRIG_RESET;
    cfg_shadow[CFG_TRIG_ROLL]  = TRIG_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values give the identity rotation
    queue_corners(6);
    drain();

    // pivots at the range ends, quarter turn, half turn and 45 degrees
    write_reg(CFG_PIVOT_X, 32'h7FFF_FFFF);
    write_reg(CFG_PIVOT_Y, 32'h8000_0000);
    write_reg(CFG_PIVOT_Z, 32'h0001_0000);
    write_reg(CFG_TRIG_YAW, 32'h0000_4000);
    write_reg(CFG_TRIG_PITCH, 32'hC000_0000);
    write_reg(CFG_TRIG_ROLL, 32'h2D41_2D41);
    queue_corners(8);
    drain();

    // non-unit pairs push the 36-bit stages into wrap
    write_reg(CFG_PIVOT_X, 32'h0000_0000);
    write_reg(CFG_PIVOT_Z, 32'h8000_0000);
    write_reg(CFG_TRIG_YAW, 32'h8000_8000);
    write_reg(CFG_TRIG_PITCH, 32'h7FFF_7FFF);
    write_reg(CFG_TRIG_ROLL, 32'h8000_7FFF);
    queue_corners(8);
    drain();

    // random phases, fresh settings each time, last ones without idling
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_PIVOT_X, random_pivot());
      write_reg(CFG_PIVOT_Y, random_pivot());
      write_reg(CFG_PIVOT_Z, random_pivot());
      write_reg(CFG_TRIG_YAW, random_trig());
      write_reg(CFG_TRIG_PITCH, random_trig());
      write_reg(CFG_TRIG_ROLL, random_trig());
      idle_pct = (p >= 8 || p % 3 == 0) ? 0 : $urandom_range(10, 40);
      @(negedge clk);
      repeat (140) vertex_q.push_back(random_vertex());
      drain();
    end

    // catch any stray beat after the last one owed
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // beat taken at this edge
      if (in_valid && in_ready) begin
        rotated_q.push_back(rotate_vertex(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (vertex_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          in_data  <= vertex_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      // compare the result beat with the oldest vertex owed
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $error("result beat with no vertex outstanding");
          error_count++;
        end else begin
          want = rotated_q.pop_front();
          check_field("x_out", want.x_out, out_data.x_out);
          check_field("y_out", want.y_out, out_data.y_out);
          check_field("z_out", want.z_out, out_data.z_out);
          check_field("saturated", 32'(want.saturated), 32'(out_data.saturated));
          check_field("last_out", 32'(want.last_out), 32'(out_data.last_out));
        end
      end
      // receiver back-pressure bursts
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule

### filelist.f
design/erap_pkg.sv
design/erap_rot.sv
design/euler_rotate_about_pivot.sv
verif/tb.sv
